// ===== sv/adc_two_point_calibration_unit_assert.svh =====
`ifndef ADC_TWO_POINT_CALIBRATION_UNIT_ASSERT_SVH
`define ADC_TWO_POINT_CALIBRATION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge while out of reset.
`define ATPC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("atpc assertion failed");

// Next-cycle implication, sampled on the rising clock edge while out of reset.
`define ATPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("atpc assertion failed");

`endif

// ===== sv/atpc_pkg.sv =====
package atpc_pkg;

	localparam int CHANNELS = 16;
	localparam int CH_W     = 4;
	localparam int SCALE    = 1000000;
	localparam int SCALE_W  = 20;

	localparam int REF_W    = 12;
	localparam int MASK_W   = 16;
	localparam int TRIM_W   = 8;
	localparam int RAW_W    = 12;
	localparam int CODE_W   = 16;
	localparam int STATUS_W = 2;

	// Stored gain and offset, both two's complement at scale SCALE.
	localparam int GAIN_W = 32;
	localparam int OFFS_W = 48;

	// Magnitude of SCALE times a trim difference; also the divider's dividend width.
	localparam int NUM_W     = 28;
	localparam int DIV_CNT_W = 5;

	// Configuration port.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam logic [1:0] REG_LOW_REF  = 2'd0;
	localparam logic [1:0] REG_HIGH_REF = 2'd1;
	localparam logic [1:0] REG_BYPASS   = 2'd2;

	localparam logic [REF_W-1:0]  LOW_REF_RESET  = 12'd2064;
	localparam logic [REF_W-1:0]  HIGH_REF_RESET = 12'd3112;
	localparam logic [MASK_W-1:0] BYPASS_RESET   = 16'hB800;

	localparam logic OP_CAL  = 1'b0;
	localparam logic OP_CORR = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_INPUT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_GAIN = 2'd2;

	// Item classes decided by the front end.
	localparam logic [1:0] KIND_CAL   = 2'd0;
	localparam logic [1:0] KIND_CORR  = 2'd1;
	localparam logic [1:0] KIND_BADCH = 2'd2;
	localparam logic [1:0] KIND_SKIP  = 2'd3;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = 1;
	localparam int CMDQ_CNT_W = 2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CH_W-1:0]   ch;
		logic [TRIM_W-1:0] trim_low;
		logic [TRIM_W-1:0] trim_high;
		logic [RAW_W-1:0]  raw;
	} cmd_t;

	typedef struct packed {
		logic [REF_W-1:0]  low_ref;
		logic [REF_W-1:0]  high_ref;
		logic [MASK_W-1:0] bypass;
	} cfg_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] steps;
		logic [GAIN_W-1:0]    rem_init;
		logic [NUM_W-1:0]     bits;
		logic [GAIN_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic [CODE_W-1:0]   code;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

// ===== sv/atpc_front.sv =====
module atpc_front import atpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              operation,
	input  logic [CH_W-1:0]   channel,
	input  logic [TRIM_W-1:0] trim_low,
	input  logic [TRIM_W-1:0] trim_high,
	input  logic [RAW_W-1:0]  raw_code,
	output cmd_t              cmd,
	output logic              cmd_valid,
	input  logic              cmd_take
);

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	cmd_t                  cmd_in;
	logic                  ch_ok;
	logic                  enq;
	logic                  deq;

	// Classify the item; a calibrate item for a missing channel is dropped here.
	always_comb begin
		ch_ok            = {1'b0, channel} < (CH_W+1)'(CHANNELS);
		cmd_in.ch        = channel;
		cmd_in.trim_low  = trim_low;
		cmd_in.trim_high = trim_high;
		cmd_in.raw       = raw_code;
		if (operation == OP_CAL) begin
			cmd_in.kind = ch_ok ? KIND_CAL : KIND_SKIP;
		end else begin
			cmd_in.kind = ch_ok ? KIND_CORR : KIND_BADCH;
		end
	end

	assign full      = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = slot_q[rd_ptr_q];
	assign enq       = push && !full && (cmd_in.kind != KIND_SKIP);
	assign deq       = cmd_take && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CMDQ_CNT_W'(enq) - CMDQ_CNT_W'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

// ===== sv/atpc_div.sv =====
module atpc_div import atpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [GAIN_W-1:0]    rem_q;
	logic [NUM_W-1:0]     bits_q;
	logic [NUM_W-1:0]     quot_q;
	logic [GAIN_W-1:0]    div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [GAIN_W:0]      trial;
	logic                 fits;
	logic [GAIN_W-1:0]    rem_next;

	// Restoring division, one quotient bit per cycle. The partial remainder
	// always stays below the divisor.
	always_comb begin
		trial    = {rem_q, bits_q[NUM_W-1]};
		fits     = (trial >= {1'b0, div_q});
		rem_next = fits ? GAIN_W'(trial - {1'b0, div_q}) : GAIN_W'(trial);
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			bits_q <= req.bits;
			div_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			bits_q <= {bits_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[NUM_W-2:0], fits};
		end
	end

endmodule

// ===== sv/atpc_back.sv =====
module atpc_back import atpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  cmd_t                cmd,
	input  logic                cmd_valid,
	output logic                cmd_take,
	output logic                empty,
	input  logic                pop,
	output logic [CODE_W-1:0]   corrected_code,
	output logic [STATUS_W-1:0] status
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CAL_PREP = 3'd1;
	localparam logic [2:0] S_CAL_DIV  = 3'd2;
	localparam logic [2:0] S_CAL_MUL  = 3'd3;
	localparam logic [2:0] S_CAL_WR   = 3'd4;
	localparam logic [2:0] S_COR_MUL  = 3'd5;
	localparam logic [2:0] S_COR_CHK  = 3'd6;
	localparam logic [2:0] S_COR_DIV  = 3'd7;

	localparam int QLO_W  = NUM_W + REF_W + 2;
	localparam int TLS_W  = TRIM_W + SCALE_W;
	localparam int RAWS_W = RAW_W + SCALE_W;
	localparam int DIFF_W = GAIN_W + CODE_W + 1;

	logic [2:0]               state_q;
	logic [2:0]               state_d;
	cmd_t                     cmd_q;
	logic signed [GAIN_W-1:0] gain_tab_q [CHANNELS];
	logic signed [OFFS_W-1:0] offs_tab_q [CHANNELS];

	logic                     neg_q;
	logic signed [NUM_W:0]    qs_q;
	logic signed [GAIN_W-1:0] gain_new_q;
	logic signed [QLO_W-1:0]  qlo_q;
	logic [TLS_W-1:0]         tls_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [GAIN_W-1:0] gain_rd_q;

	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	res_t                     res_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0]    res_wr_q;
	logic [CMDQ_PTR_W-1:0]    res_rd_q;
	logic [CMDQ_CNT_W-1:0]    res_cnt_q;
	logic                     res_room;
	logic                     res_push;
	logic                     res_pop;
	res_t                     res_in;

	logic                     trim_neg;
	logic [TRIM_W-1:0]        trim_mag;
	logic [NUM_W-1:0]         num_mag;
	logic                     span_neg;
	logic                     span_zero;
	logic [REF_W-1:0]         span_mag;
	logic signed [NUM_W:0]    quot_signed;
	logic signed [QLO_W-1:0]  qs_ext;
	logic signed [QLO_W-1:0]  lo_ext;
	logic signed [QLO_W-1:0]  qlo_n;
	logic signed [GAIN_W-1:0] gain_n;
	logic [TLS_W-1:0]         tls_n;
	logic signed [OFFS_W-1:0] offs_n;
	logic [RAWS_W-1:0]        raws;
	logic signed [DIFF_W-1:0] raws_ext;
	logic signed [DIFF_W-1:0] offs_ext;
	logic signed [DIFF_W-1:0] diff_n;
	logic                     gain_bad;
	logic                     sat;

	atpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Datapath for calibration: magnitudes go through the divider, the sign is
	// restored afterwards so the quotient truncates toward zero.
	always_comb begin
		trim_neg    = (cmd_q.trim_high < cmd_q.trim_low);
		trim_mag    = trim_neg ? (cmd_q.trim_low - cmd_q.trim_high)
		                       : (cmd_q.trim_high - cmd_q.trim_low);
		num_mag     = NUM_W'(NUM_W'(trim_mag) * NUM_W'(SCALE));
		span_neg    = (cfg.low_ref > cfg.high_ref);
		span_zero   = (cfg.low_ref == cfg.high_ref);
		span_mag    = span_neg ? (cfg.low_ref - cfg.high_ref) : (cfg.high_ref - cfg.low_ref);
		quot_signed = neg_q ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
		qs_ext      = {{(QLO_W-NUM_W-1){qs_q[NUM_W]}}, qs_q};
		lo_ext      = $signed(QLO_W'(cfg.low_ref));
		qlo_n       = qs_ext * lo_ext;
		gain_n      = $signed(GAIN_W'(SCALE) + {{(GAIN_W-NUM_W-1){qs_q[NUM_W]}}, qs_q});
		tls_n       = TLS_W'(TLS_W'(cmd_q.trim_low) * TLS_W'(SCALE));
		offs_n      = $signed(OFFS_W'(tls_q)) - {{(OFFS_W-QLO_W){qlo_q[QLO_W-1]}}, qlo_q};
	end

	// Datapath for correction.
	always_comb begin
		raws     = RAWS_W'(RAWS_W'(cmd_q.raw) * RAWS_W'(SCALE));
		raws_ext = $signed(DIFF_W'(raws));
		offs_ext = {{(DIFF_W-OFFS_W){offs_tab_q[cmd_q.ch][OFFS_W-1]}}, offs_tab_q[cmd_q.ch]};
		diff_n   = raws_ext - offs_ext;
		gain_bad = gain_rd_q[GAIN_W-1] || (gain_rd_q == '0);
		sat      = (diff_q >= $signed({1'b0, gain_rd_q, {CODE_W{1'b0}}}));
	end

	assign res_room = (res_cnt_q != CMDQ_CNT_W'(CMDQ_DEPTH));

	always_comb begin
		state_d          = state_q;
		cmd_take         = 1'b0;
		res_push         = 1'b0;
		res_in.code      = '0;
		res_in.status    = ST_OK;
		div_req.start    = 1'b0;
		div_req.steps    = DIV_CNT_W'(NUM_W);
		div_req.rem_init = '0;
		div_req.bits     = num_mag;
		div_req.divisor  = GAIN_W'(span_mag);
		case (state_q)
			S_IDLE: begin
				if (cmd_valid && res_room) begin
					cmd_take = 1'b1;
					case (cmd.kind)
						KIND_CAL:  state_d = S_CAL_PREP;
						KIND_CORR: state_d = S_COR_MUL;
						default: begin
							res_push      = 1'b1;
							res_in.status = ST_BAD_GAIN;
						end
					endcase
				end
			end
			S_CAL_PREP: begin
				if (span_zero) begin
					state_d = S_CAL_MUL;
				end else begin
					div_req.start = 1'b1;
					state_d       = S_CAL_DIV;
				end
			end
			S_CAL_DIV: begin
				if (div_rsp.done) begin
					state_d = S_CAL_MUL;
				end
			end
			S_CAL_MUL: state_d = S_CAL_WR;
			S_CAL_WR:  state_d = S_IDLE;
			S_COR_MUL: state_d = S_COR_CHK;
			S_COR_CHK: begin
				state_d = S_IDLE;
				if (diff_q[DIFF_W-1]) begin
					res_push      = 1'b1;
					res_in.status = ST_NO_INPUT;
				end else if (cfg.bypass[cmd_q.ch]) begin
					res_push    = 1'b1;
					res_in.code = CODE_W'(cmd_q.raw);
				end else if (gain_bad) begin
					res_push      = 1'b1;
					res_in.status = ST_BAD_GAIN;
				end else if (sat) begin
					res_push    = 1'b1;
					res_in.code = '1;
				end else begin
					// The quotient is known to fit in CODE_W bits, so the upper
					// dividend bits already form a remainder below the gain.
					div_req.start    = 1'b1;
					div_req.steps    = DIV_CNT_W'(CODE_W);
					div_req.rem_init = GAIN_W'(diff_q[DIFF_W-2:CODE_W]);
					div_req.bits     = {diff_q[CODE_W-1:0], {(NUM_W-CODE_W){1'b0}}};
					div_req.divisor  = gain_rd_q;
					state_d          = S_COR_DIV;
				end
			end
			S_COR_DIV: begin
				if (div_rsp.done) begin
					res_push    = 1'b1;
					res_in.code = div_rsp.quot[CODE_W-1:0];
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < CHANNELS; i++) begin
				gain_tab_q[i] <= GAIN_W'(SCALE);
				offs_tab_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_CAL_WR) begin
				gain_tab_q[cmd_q.ch] <= gain_new_q;
				offs_tab_q[cmd_q.ch] <= offs_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
		case (state_q)
			S_CAL_PREP: begin
				neg_q <= trim_neg ^ span_neg;
				qs_q  <= '0;
			end
			S_CAL_DIV: begin
				if (div_rsp.done) begin
					qs_q <= quot_signed;
				end
			end
			S_CAL_MUL: begin
				gain_new_q <= gain_n;
				qlo_q      <= qlo_n;
				tls_q      <= tls_n;
			end
			S_COR_MUL: begin
				diff_q    <= diff_n;
				gain_rd_q <= gain_tab_q[cmd_q.ch];
			end
			default: ;
		endcase
	end

	// Result queue toward the consumer.
	assign res_pop        = pop && !empty;
	assign empty          = (res_cnt_q == '0);
	assign corrected_code = res_q[res_rd_q].code;
	assign status         = res_q[res_rd_q].status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (res_push) begin
				res_wr_q <= res_wr_q + 1'b1;
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + 1'b1;
			end
			res_cnt_q <= res_cnt_q + CMDQ_CNT_W'(res_push) - CMDQ_CNT_W'(res_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wr_q] <= res_in;
		end
	end

endmodule

// ===== sv/adc_two_point_calibration_unit.sv =====
// Two-point gain and offset correction for a 16-channel converter.
// Items enter through a queue-style port: an item is taken on a rising edge
// with push high and full low. Operation 0 calibrates one channel from its two
// trim bytes and the two reference codes and yields no result; operation 1
// corrects one raw code and yields exactly one result (code and status).
// Results leave through a queue-style port: while empty is low the oldest
// result is on corrected_code and status, and pop high takes it.
// With the back end free, a correct item that needs the divider (16 quotient
// bits, one per cycle) passes S_COR_MUL, S_COR_CHK and S_COR_DIV before its
// result is queued, and one that ends early on no input, bypass, invalid gain
// or saturation is queued from S_COR_CHK. A calibrate item holds the back end
// for a division of 28 quotient bits, skipped with equal reference codes.
// One item is worked on at a time; a two-entry input queue lets the source
// run ahead, and a two-entry result queue lets the back end finish while the
// receiver stalls. When that queue is full the back end holds off the next
// item and the input queue then fills and raises full.
// Reset clears both queues, sets every channel to unity gain and zero offset
// and loads the reference codes and bypass mask with their defaults.
// The user must write configuration over the APB port only while the block is idle; the block does not enforce it.
module adc_two_point_calibration_unit import atpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Item input.
	input  logic                push,
	output logic                full,
	input  logic                operation,
	input  logic [CH_W-1:0]     channel,
	input  logic [TRIM_W-1:0]   trim_low,
	input  logic [TRIM_W-1:0]   trim_high,
	input  logic [RAW_W-1:0]    raw_code,
	// Result output.
	output logic                empty,
	input  logic                pop,
	output logic [CODE_W-1:0]   corrected_code,
	output logic [STATUS_W-1:0] status,
	// Configuration port.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	cfg_t cfg_q;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;
	logic cfg_wr;

	// Registers sit on word addresses; the low two address bits are ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_ref  <= LOW_REF_RESET;
			cfg_q.high_ref <= HIGH_REF_RESET;
			cfg_q.bypass   <= BYPASS_RESET;
		end else if (cfg_wr) begin
			case (paddr[ADDR_W-1:2])
				REG_LOW_REF:  cfg_q.low_ref  <= pwdata[REF_W-1:0];
				REG_HIGH_REF: cfg_q.high_ref <= pwdata[REF_W-1:0];
				REG_BYPASS:   cfg_q.bypass   <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_LOW_REF:  prdata = DATA_W'(cfg_q.low_ref);
			REG_HIGH_REF: prdata = DATA_W'(cfg_q.high_ref);
			REG_BYPASS:   prdata = DATA_W'(cfg_q.bypass);
			default:      prdata = '0;
		endcase
	end

	// The front end classifies items and buffers them.
	atpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.channel   (channel),
		.trim_low  (trim_low),
		.trim_high (trim_high),
		.raw_code  (raw_code),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take)
	);

	// The back end holds the channel tables, runs the arithmetic and the
	// divider, and queues results for the consumer.
	atpc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.cmd_valid      (cmd_valid),
		.cmd_take       (cmd_take),
		.empty          (empty),
		.pop            (pop),
		.corrected_code (corrected_code),
		.status         (status)
	);

endmodule

// ===== sv/atpc_checker.sv =====
`include "adc_two_point_calibration_unit_assert.svh"

module atpc_checker import atpc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input logic [CODE_W-1:0]   corrected_code,
	input logic [STATUS_W-1:0] status
);

	// A shown result carries one of the defined status codes.
	`ATPC_ASSERT_NOW(a_status_known, !empty, status == ST_OK || status == ST_NO_INPUT || status == ST_BAD_GAIN)

	// Error statuses always come with a zero code.
	`ATPC_ASSERT_NOW(a_no_input_zero, !empty && status == ST_NO_INPUT, corrected_code == '0)
	`ATPC_ASSERT_NOW(a_bad_gain_zero, !empty && status == ST_BAD_GAIN, corrected_code == '0)

	// A result that is not taken stays in place.
	`ATPC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(corrected_code) && $stable(status))

endmodule

bind adc_two_point_calibration_unit atpc_checker u_atpc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.corrected_code (corrected_code),
	.status         (status)
);

// ===== sim/tb_adc_two_point_calibration_unit.sv =====
// Self-checking testbench for adc_two_point_calibration_unit.
// Every item the block takes is also run through a predictor kept here.
// Calibrate items update its gain and offset tables. Correct items add the
// expected code and status to a queue. A checker process compares each
// result the block returns with the oldest entry in that queue.
module tb_adc_two_point_calibration_unit import atpc_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SCALE_L     = SCALE;
	// A calibrate item yields no result, so the block may still be busy after the
	// last expected result has arrived: up to three calibrate items can remain
	// queued, and IDLE_WAIT covers them with margin.
	localparam int     IDLE_WAIT   = 160;
	localparam int     HOLD_CYCLES = 400;
	localparam int     STALL_LIMIT = 3000;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	logic                operation;
	logic [CH_W-1:0]     channel;
	logic [TRIM_W-1:0]   trim_low;
	logic [TRIM_W-1:0]   trim_high;
	logic [RAW_W-1:0]    raw_code;
	logic                empty;
	logic                pop;
	logic [CODE_W-1:0]   corrected_code;
	logic [STATUS_W-1:0] status;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// Predictor state: configuration and per-channel calibration tables.
	logic [REF_W-1:0]  low_ref_model;
	logic [REF_W-1:0]  high_ref_model;
	logic [MASK_W-1:0] bypass_model;
	longint signed     gain_model [CHANNELS];
	longint signed     offset_model [CHANNELS];

	// Results still owed by the block, oldest first.
	res_t pending_corrections [$];

	int   error_count;
	int   stall_cycles;
	// Random idling on either side; both are switched off for the last phase.
	bit   sender_idles;
	bit   receiver_idles;
	// Asks the result side to hold off for HOLD_CYCLES so that the block fills up.
	bit   hold_request;

	adc_two_point_calibration_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.operation      (operation),
		.channel        (channel),
		.trim_low       (trim_low),
		.trim_high      (trim_high),
		.raw_code       (raw_code),
		.empty          (empty),
		.pop            (pop),
		.corrected_code (corrected_code),
		.status         (status),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic report_mismatch(input string msg);
		begin
			$display("mismatch at %0t: %s", $realtime, msg);
			error_count++;
		end
	endtask

	// Two-point calibration: the gain follows from the slope between the trim
	// readings and the reference codes. The offset is chosen so that a raw code
	// of trim_low plus low_ref maps back to low_ref. Equal references leave unity gain.
	task automatic apply_trim_calibration(input logic [CH_W-1:0] ch,
			input logic [TRIM_W-1:0] tl_in, input logic [TRIM_W-1:0] th_in);
		longint signed lo;
		longint signed hi;
		longint signed span;
		longint signed tl;
		longint signed th;
		longint signed g;
		begin
			lo = low_ref_model;
			hi = high_ref_model;
			tl = tl_in;
			th = th_in;
			span = hi - lo;
			g = SCALE_L;
			if (span != 0) begin
				// Signed division truncates toward zero, as the hardware does.
				g = g + (SCALE_L * (th - tl)) / span;
			end
			gain_model[ch] = g;
			offset_model[ch] = tl * SCALE_L - (g - SCALE_L) * lo;
		end
	endtask

	// The checks come in a fixed order. A negative difference means no input,
	// and that takes precedence even on bypass channels. Next come bypass, then
	// a gain that is not positive, and last the saturated quotient.
	function automatic res_t predict_correction(input logic [CH_W-1:0] ch,
			input logic [RAW_W-1:0] raw);
		longint signed raw_s;
		longint signed diff;
		longint signed q;
		res_t r;
		begin
			raw_s = raw;
			diff = raw_s * SCALE_L - offset_model[ch];
			r.code = '0;
			r.status = ST_OK;
			if (diff < 0) begin
				r.status = ST_NO_INPUT;
			end else if (bypass_model[ch]) begin
				r.code = CODE_W'(raw);
			end else if (gain_model[ch] <= 0) begin
				r.status = ST_BAD_GAIN;
			end else begin
				q = diff / gain_model[ch];
				r.code = (q > 65535) ? {CODE_W{1'b1}} : q[CODE_W-1:0];
			end
			return r;
		end
	endfunction

	// Offers one item and waits until the block takes it. push stays high when
	// the next item follows at once. Otherwise a random gap lowers it.
	task automatic send_item(input logic op, input logic [CH_W-1:0] ch,
			input logic [TRIM_W-1:0] tl, input logic [TRIM_W-1:0] th,
			input logic [RAW_W-1:0] raw);
		begin
			push      <= 1'b1;
			operation <= op;
			channel   <= ch;
			trim_low  <= tl;
			trim_high <= th;
			raw_code  <= raw;
			do @(posedge clk); while (full);
			if (op == OP_CAL) begin
				apply_trim_calibration(ch, tl, th);
			end else begin
				pending_corrections.push_back(predict_correction(ch, raw));
			end
			if (sender_idles && $urandom_range(0, 5) == 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	endtask

	// Stops offering items and waits until every owed result has arrived. The
	// block then gets time to finish any calibrate item still in flight.
	task automatic wait_idle();
		begin
			push <= 1'b0;
			while (pending_corrections.size() != 0) @(posedge clk);
			repeat (IDLE_WAIT) @(posedge clk);
		end
	endtask

	// APB write (a setup phase, then an access phase) followed by a read-back of
	// the same register. The predictor takes the value as the register keeps it.
	task automatic program_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] kept;
		begin
			case (idx)
				REG_LOW_REF:  kept = DATA_W'(value[REF_W-1:0]);
				REG_HIGH_REF: kept = DATA_W'(value[REF_W-1:0]);
				default:      kept = DATA_W'(value[MASK_W-1:0]);
			endcase
			@(posedge clk);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= ADDR_W'({idx, 2'b00});
			pwdata  <= value;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			case (idx)
				REG_LOW_REF:  low_ref_model = kept[REF_W-1:0];
				REG_HIGH_REF: high_ref_model = kept[REF_W-1:0];
				default:      bypass_model = kept[MASK_W-1:0];
			endcase
			penable <= 1'b0;
			pwrite  <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata !== kept) begin
				report_mismatch($sformatf("register %0d reads %h, expected %h",
					idx, prdata, kept));
			end
			psel    <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	function automatic logic [TRIM_W-1:0] pick_trim();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return {TRIM_W{1'b1}};
			default: return TRIM_W'($urandom);
		endcase
	endfunction

	// Out of reset every channel has unity gain and zero offset. Unmasked channels
	// therefore return the raw code unchanged, and so do the bypassed ones.
	task automatic test_reset_defaults();
		begin
			send_item(OP_CORR, 4'd0, 8'd0, 8'd0, 12'd0);
			send_item(OP_CORR, 4'd0, 8'd255, 8'd255, 12'd4095);
			send_item(OP_CORR, 4'd15, 8'd0, 8'd0, 12'd4095);
			send_item(OP_CORR, 4'd11, 8'd0, 8'd0, 12'd0);
			wait_idle();
		end
	endtask

	// Calibration with the default references. One channel has a rising slope
	// and one a falling slope, and the second makes a raw code of zero read as
	// no input. A bypass channel with a large offset still reports no input
	// below that offset and passes the raw code through above it.
	task automatic test_calibration_and_correction();
		begin
			send_item(OP_CAL, 4'd1, 8'd0, 8'd255, 12'd0);
			send_item(OP_CORR, 4'd1, 8'd0, 8'd0, 12'd0);
			send_item(OP_CORR, 4'd1, 8'd0, 8'd0, 12'd4095);
			send_item(OP_CAL, 4'd2, 8'd255, 8'd0, 12'd4095);
			send_item(OP_CORR, 4'd2, 8'd0, 8'd0, 12'd0);
			send_item(OP_CAL, 4'd15, 8'd200, 8'd200, 12'd0);
			send_item(OP_CORR, 4'd15, 8'd0, 8'd0, 12'd100);
			send_item(OP_CORR, 4'd15, 8'd0, 8'd0, 12'd300);
			wait_idle();
		end
	endtask

	// With equal reference codes the slope is undefined. The gain stays at unity
	// and only the offset moves.
	task automatic test_equal_references();
		begin
			program_register(REG_LOW_REF, 32'd500);
			program_register(REG_HIGH_REF, 32'd500);
			send_item(OP_CAL, 4'd3, 8'd7, 8'd99, 12'd0);
			send_item(OP_CORR, 4'd3, 8'd0, 8'd0, 12'd7);
			send_item(OP_CORR, 4'd3, 8'd0, 8'd0, 12'd6);
			wait_idle();
		end
	endtask

	// A narrow span of ten codes makes the gain exactly zero on one channel and
	// negative on another. Both must report an invalid gain.
	task automatic test_invalid_gain();
		begin
			program_register(REG_LOW_REF, 32'd100);
			program_register(REG_HIGH_REF, 32'd110);
			program_register(REG_BYPASS, 32'h0000_0000);
			send_item(OP_CAL, 4'd4, 8'd20, 8'd10, 12'd0);
			send_item(OP_CORR, 4'd4, 8'd0, 8'd0, 12'd4095);
			send_item(OP_CAL, 4'd5, 8'd255, 8'd0, 12'd0);
			send_item(OP_CORR, 4'd5, 8'd0, 8'd0, 12'd4095);
			wait_idle();
		end
	endtask

	// A tiny positive gain pushes the quotient far past 16 bits, so the output
	// must clip. Reversed references (low above high) give a negative span.
	task automatic test_saturation_and_reversed_span();
		begin
			program_register(REG_LOW_REF, 32'd100);
			program_register(REG_HIGH_REF, 32'd356);
			send_item(OP_CAL, 4'd6, 8'd255, 8'd0, 12'd0);
			send_item(OP_CORR, 4'd6, 8'd0, 8'd0, 12'd4095);
			send_item(OP_CORR, 4'd6, 8'd0, 8'd0, 12'd400);
			wait_idle();
			program_register(REG_LOW_REF, 32'd4095);
			program_register(REG_HIGH_REF, 32'd0);
			send_item(OP_CAL, 4'd7, 8'd0, 8'd255, 12'd0);
			send_item(OP_CORR, 4'd7, 8'd0, 8'd0, 12'd2048);
			wait_idle();
		end
	endtask

	// The result side holds off while correct items keep coming. Both internal
	// queues fill up and full must stall the sender. Nothing may be lost.
	task automatic test_result_backpressure();
		bit saved;
		begin
			saved = sender_idles;
			sender_idles = 1'b0;
			hold_request = 1'b1;
			repeat (12) send_item(OP_CORR, CH_W'($urandom), 8'd0, 8'd0, RAW_W'($urandom));
			sender_idles = saved;
			wait_idle();
		end
	endtask

	// One phase of random traffic under a given configuration. Most of it consists
	// of well-formed sequences: a calibration of one channel, then corrections
	// on that channel with raw codes near its two calibration points or random.
	// The rest is loose items of either kind.
	task automatic run_traffic_phase(input int item_total, input logic [DATA_W-1:0] lo,
			input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] mask);
		int sent;
		int center;
		int jitter;
		int raw_i;
		logic [CH_W-1:0] ch;
		logic [TRIM_W-1:0] tl;
		logic [TRIM_W-1:0] th;
		begin
			wait_idle();
			program_register(REG_LOW_REF, lo);
			program_register(REG_HIGH_REF, hi);
			program_register(REG_BYPASS, mask);
			sent = 0;
			while (sent < item_total) begin
				if ($urandom_range(0, 3) != 0) begin
					ch = CH_W'($urandom);
					tl = pick_trim();
					th = pick_trim();
					send_item(OP_CAL, ch, tl, th, RAW_W'($urandom));
					sent++;
					repeat ($urandom_range(1, 6)) begin
						case ($urandom_range(0, 3))
							0: center = int'(tl) + int'(low_ref_model);
							1: center = int'(th) + int'(high_ref_model);
							default: center = -1;
						endcase
						if (center < 0) begin
							raw_i = $urandom_range(0, 4095);
						end else begin
							jitter = $urandom_range(0, 64);
							raw_i = center + jitter - 32;
							if (raw_i < 0) raw_i = 0;
							if (raw_i > 4095) raw_i = 4095;
						end
						send_item(OP_CORR, ch, TRIM_W'($urandom), TRIM_W'($urandom),
							RAW_W'(raw_i));
						sent++;
					end
				end else begin
					send_item(1'($urandom), CH_W'($urandom), TRIM_W'($urandom),
						TRIM_W'($urandom), RAW_W'($urandom));
					sent++;
				end
			end
			wait_idle();
		end
	endtask

	task automatic test_random_traffic();
		begin
			run_traffic_phase(100, 32'd2064, 32'd3112, 32'h0000_B800);
			run_traffic_phase(100, 32'd0, 32'd4095, 32'h0000_0000);
			run_traffic_phase(100, 32'd4095, 32'd0, 32'hFFFF_FFFF);
			run_traffic_phase(100, 32'd1000, 32'd1000, $urandom);
			run_traffic_phase(100, $urandom, $urandom, $urandom);
			run_traffic_phase(100, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
			// The closing phase runs at full rate on both sides.
			sender_idles = 1'b0;
			receiver_idles = 1'b0;
			run_traffic_phase(100, $urandom_range(0, 2000), $urandom_range(2000, 4095),
				$urandom);
		end
	endtask

	// Predictor reset state matches the block after reset.
	initial begin
		low_ref_model = LOW_REF_RESET;
		high_ref_model = HIGH_REF_RESET;
		bypass_model = BYPASS_RESET;
		for (int i = 0; i < CHANNELS; i++) begin
			gain_model[i] = SCALE_L;
			offset_model[i] = 0;
		end
	end

	// Result side: pop is high most of the time, broken by random stalls. A hold
	// request keeps pop low for a long counted stretch.
	initial begin
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Each result taken is compared with the oldest prediction, field by field.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_corrections.size() == 0) begin
				report_mismatch($sformatf("unexpected result code %0d status %0d",
					corrected_code, status));
			end else begin
				want = pending_corrections.pop_front();
				if (corrected_code !== want.code) begin
					report_mismatch($sformatf("corrected_code %0d, expected %0d",
						corrected_code, want.code));
				end
				if (status !== want.status) begin
					report_mismatch($sformatf("status %0d, expected %0d",
						status, want.status));
				end
			end
		end
	end

	// Watchdog: a long run of cycles in which no item moves on either side means
	// the block has hung or is holding back a result.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		operation = OP_CAL;
		channel = '0;
		trim_low = '0;
		trim_high = '0;
		raw_code = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		error_count = 0;
		stall_cycles = 0;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		hold_request = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_calibration_and_correction();
		test_equal_references();
		test_invalid_gain();
		test_saturation_and_reversed_span();
		test_result_backpressure();
		test_random_traffic();

		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
